@@ rtl/core/rcl_pkg.sv @@
package rcl_pkg;

	localparam int unsigned IDX_W   = 12;
	localparam int unsigned RANGE_W = 13;
	localparam int unsigned COL_W   = 8;
	localparam int unsigned SEG_W   = 3;
	localparam int unsigned NUM_W   = IDX_W + COL_W;

	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = QPTR_W + 1;

	localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(256);

	// x/6 as (x*43691)>>18, exact for x below 2**17
	localparam int unsigned DIV6_MUL   = 43691;
	localparam int unsigned DIV6_SHIFT = 18;

	typedef logic [SEG_W-1:0]   seg_t;
	typedef logic [RANGE_W-1:0] bound_t;
	typedef logic [COL_W-1:0]   col_t;

	localparam seg_t SEG_RED_ORANGE    = 3'd0;
	localparam seg_t SEG_ORANGE_YELLOW = 3'd1;
	localparam seg_t SEG_YELLOW_GREEN  = 3'd2;
	localparam seg_t SEG_GREEN_CYAN    = 3'd3;
	localparam seg_t SEG_CYAN_BLUE     = 3'd4;
	localparam seg_t SEG_BLUE_MAGENTA  = 3'd5;

	localparam col_t COL_MAX      = 8'd255;
	localparam col_t COL_ORANGE_G = 8'd122;

	localparam logic [SEG_W-1:0] SWEEP_FIRST = 3'd1;
	localparam logic [SEG_W-1:0] SWEEP_LAST  = 3'd6;

	typedef struct packed {
		logic         busy;
		bound_t [6:1] b;
	} bnd_t;

	typedef struct packed {
		logic oor;
		seg_t seg;
		logic [IDX_W-1:0] off;
		logic [IDX_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		col_t red;
		col_t green;
		col_t blue;
	} rgb_t;

	// magnitude of the one pivot step that changes within a segment
	function automatic col_t seg_mag(seg_t seg);
		col_t m;
		case (seg)
			SEG_RED_ORANGE:    m = COL_ORANGE_G;
			SEG_ORANGE_YELLOW: m = COL_MAX - COL_ORANGE_G;
			default:           m = COL_MAX;
		endcase
		return m;
	endfunction

	function automatic rgb_t shade(seg_t seg, col_t q);
		rgb_t c;
		case (seg)
			SEG_RED_ORANGE:    c = '{red: COL_MAX, green: q, blue: '0};
			SEG_ORANGE_YELLOW: c = '{red: COL_MAX, green: COL_ORANGE_G + q, blue: '0};
			SEG_YELLOW_GREEN:  c = '{red: COL_MAX - q, green: COL_MAX, blue: '0};
			SEG_GREEN_CYAN:    c = '{red: '0, green: COL_MAX, blue: q};
			SEG_CYAN_BLUE:     c = '{red: '0, green: COL_MAX - q, blue: COL_MAX};
			SEG_BLUE_MAGENTA:  c = '{red: q, green: '0, blue: COL_MAX};
			default:           c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/rcl_if.sv @@
interface rcl_in_if;
	logic                      valid;
	logic                      ready;
	logic [rcl_pkg::IDX_W-1:0] index;

	modport source (output valid, output index, input ready);
	modport sink   (input valid, input index, output ready);
endinterface

interface rcl_out_if;
	logic                      valid;
	logic                      ready;
	logic [rcl_pkg::COL_W-1:0] red;
	logic [rcl_pkg::COL_W-1:0] green;
	logic [rcl_pkg::COL_W-1:0] blue;
	logic                      out_of_range;

	modport source (output valid, output red, output green, output blue,
		output out_of_range, input ready);
	modport sink   (input valid, input red, input green, input blue,
		input out_of_range, output ready);
endinterface

interface rcl_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rcl_pkg::RANGE_W-1:0] range;

	modport source (output valid, output range, input ready);
	modport sink   (input valid, input range, output ready);
endinterface

@@ rtl/core/rcl_queue.sv @@
module rcl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcl_pkg::job_t   push_job,
	input  logic            pop,
	output rcl_pkg::job_t   head,
	output rcl_pkg::qstat_t stat
);

	rcl_pkg::job_t                    mem_q [rcl_pkg::QDEPTH];
	logic [rcl_pkg::QPTR_W-1:0]       wp_q;
	logic [rcl_pkg::QPTR_W-1:0]       rp_q;
	logic [rcl_pkg::QCNT_W-1:0]       cnt_q;

	assign head       = mem_q[rp_q];
	assign stat.full  = (cnt_q == rcl_pkg::QCNT_W'(rcl_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_job;
	end

endmodule

@@ rtl/core/rcl_bounds.sv @@
module rcl_bounds #(
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	rcl_cfg_if.sink       cfg,
	output rcl_pkg::bnd_t bnd
);

	logic [rcl_pkg::RANGE_W-1:0] range_q;
	logic [rcl_pkg::SEG_W-1:0]   k_q;
	rcl_pkg::bound_t [6:1]       b_q;

	logic                        clamp;
	logic [rcl_pkg::RANGE_W-1:0] r_eff;
	logic [15:0]                 rk;
	logic [31:0]                 prod;
	rcl_pkg::bound_t             quot;

	assign cfg.ready = 1'b1;

	assign clamp = 32'(range_q) > MAX_ENTRIES;
	assign r_eff = clamp ? rcl_pkg::RANGE_W'(MAX_ENTRIES) : range_q;
	assign rk    = 16'(r_eff) * 16'(k_q);
	assign prod  = 32'(rk) * 32'(rcl_pkg::DIV6_MUL);
	assign quot  = prod[rcl_pkg::DIV6_SHIFT +: rcl_pkg::RANGE_W];

	// one bound per cycle, k = 1..6, after reset and after every write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= rcl_pkg::RANGE_RESET;
			k_q     <= rcl_pkg::SWEEP_FIRST;
		end else if (cfg.valid && cfg.ready) begin
			range_q <= cfg.range;
			k_q     <= rcl_pkg::SWEEP_FIRST;
		end else if (k_q != '0) begin
			k_q <= (k_q == rcl_pkg::SWEEP_LAST) ? '0 : k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (k_q != '0)
			b_q[k_q] <= quot;
	end

	assign bnd.busy = (k_q != '0);
	assign bnd.b    = b_q;

endmodule

@@ rtl/core/rcl_front.sv @@
module rcl_front (
	rcl_in_if.sink          item,
	input  rcl_pkg::bnd_t   bnd,
	input  rcl_pkg::qstat_t qs,
	output logic            push,
	output rcl_pkg::job_t   job
);

	rcl_pkg::bound_t             b [0:6];
	logic [rcl_pkg::RANGE_W-1:0] idx_ext;
	logic [5:1]                  ge;
	rcl_pkg::seg_t               seg;
	rcl_pkg::bound_t             lo;
	rcl_pkg::bound_t             hi;

	assign item.ready = !bnd.busy && !qs.full;
	assign push       = item.valid && item.ready;
	assign idx_ext    = rcl_pkg::RANGE_W'(item.index);

	always_comb begin
		b[0] = '0;
		for (int k = 1; k <= 6; k++)
			b[k] = bnd.b[k];
		for (int k = 1; k <= 5; k++)
			ge[k] = idx_ext >= bnd.b[k];
	end

	// bounds are monotone, so the segment is the count of bounds passed
	assign seg = rcl_pkg::SEG_W'($countones(ge));
	assign lo  = b[seg];
	assign hi  = b[rcl_pkg::SEG_W'(seg + 1'b1)];

	assign job.oor = idx_ext >= bnd.b[6];
	assign job.seg = seg;
	assign job.off = item.index - lo[rcl_pkg::IDX_W-1:0];
	assign job.len = rcl_pkg::IDX_W'(hi - lo);

endmodule

@@ rtl/core/rcl_back.sv @@
module rcl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rcl_pkg::job_t   head,
	input  rcl_pkg::qstat_t qs,
	output logic            pop,
	rcl_out_if.source       result
);

	localparam int unsigned STEPS = rcl_pkg::COL_W;

	logic                          adv;
	logic                          out_valid_q;
	rcl_pkg::rgb_t                 rgb_q;
	logic                          oor_q;
	rcl_pkg::rgb_t                 rgb_nxt;

	// index 0 is the product stage, index i+1 the result of divide step i
	logic                          v_s   [0:STEPS];
	logic [rcl_pkg::NUM_W-1:0]     rem_s [0:STEPS];
	rcl_pkg::col_t                 q_s   [0:STEPS];
	logic [rcl_pkg::IDX_W-1:0]     len_s [0:STEPS];
	rcl_pkg::seg_t                 seg_s [0:STEPS];
	logic                          oor_s [0:STEPS];

	assign adv = !out_valid_q || result.ready;
	assign pop = adv && !qs.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (adv)
			v_s[0] <= pop;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= rcl_pkg::NUM_W'(rcl_pkg::seg_mag(head.seg))
				* rcl_pkg::NUM_W'(head.off);
			q_s[0]   <= '0;
			len_s[0] <= head.len;
			seg_s[0] <= head.seg;
			oor_s[0] <= head.oor;
		end
	end

	// restoring divide, one quotient bit per stage, msb first
	for (genvar i = 0; i < STEPS; i++) begin : g_div
		localparam int unsigned SH = STEPS - 1 - i;
		logic [rcl_pkg::NUM_W-1:0] dsh;
		logic                      take;

		assign dsh  = rcl_pkg::NUM_W'(len_s[i]) << SH;
		assign take = rem_s[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (adv)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= take ? rem_s[i] - dsh : rem_s[i];
				q_s[i+1]   <= {q_s[i][STEPS-2:0], take};
				len_s[i+1] <= len_s[i];
				seg_s[i+1] <= seg_s[i];
				oor_s[i+1] <= oor_s[i];
			end
		end
	end

	assign rgb_nxt = oor_s[STEPS] ? '0 : rcl_pkg::shade(seg_s[STEPS], q_s[STEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_q <= rgb_nxt;
			oor_q <= oor_s[STEPS];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.red          = rgb_q.red;
	assign result.green        = rgb_q.green;
	assign result.blue         = rgb_q.blue;
	assign result.out_of_range = oor_q;

endmodule

@@ rtl/core/rainbow_colormap_lookup_core.sv @@
// channel   modport  payload                               accepted when
// item      sink     index[11:0]                           item.valid && item.ready
// result    source   red, green, blue[7:0], out_of_range   result.valid && result.ready
// cfg       sink     range[12:0]                           cfg.valid && cfg.ready
//
// one item per cycle sustained while result.ready is high and bounds are idle; path:
// queue, product stage reading the queue head, 8-stage restoring divider, output register
// after reset and after each cfg write the six segment bounds are recomputed, one per cycle,
// by a single multiply-and-divide datapath; item.ready stays low while they are recomputed
// a stalled result freezes the back pipeline; the 4-entry queue takes up to four more
// transactions before item.ready drops
// arst_n clears control state only; the register resets to a range of 256
module rainbow_colormap_lookup_core #(
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	rcl_in_if.sink    item,
	rcl_out_if.source result,
	rcl_cfg_if.sink   cfg
);

	rcl_pkg::bnd_t   bnd;
	rcl_pkg::qstat_t qs;
	rcl_pkg::job_t   push_job;
	rcl_pkg::job_t   head;
	logic            push;
	logic            pop;

	rcl_bounds #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.bnd    (bnd)
	);

	rcl_front u_front (
		.item (item),
		.bnd  (bnd),
		.qs   (qs),
		.push (push),
		.job  (push_job)
	);

	rcl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qs)
	);

	rcl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qs     (qs),
		.pop    (pop),
		.result (result)
	);

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.out_of_range |->
			result.red == '0 && result.green == '0 && result.blue == '0)
		else $error("out of range result carries a color");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready |=> !item.ready)
		else $error("item taken while bounds are being rebuilt");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty)
		else $error("queue read while empty");

endmodule
